>>> hw/rtl/rsn_pkg.sv
// Package of the ray-sphere nearest-hit block: field widths, register indexes,
// controller states and the control struct of a target cell. No dependencies.
package rsn_pkg;

    // Default size of the target table.
    localparam int NUM_TARGETS_DEF = 8;

    // Field widths.
    localparam int SLOT_W    = 3;
    localparam int POS_W     = 16;
    localparam int DIR_W     = 16;
    localparam int DIST_W    = 15;
    localparam int CENTER_W  = 3 * POS_W;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 24;

    // Arithmetic widths of the test unit.
    localparam int MUL_W  = 21;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 38;
    localparam int DISC_W = 44;
    localparam int ROOT_W = DISC_W / 2;
    localparam int T_W    = 24;
    localparam int B_SHIFT = 14;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SHOOT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HIT_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd2;

    // Multiply steps of one target test.
    localparam logic [3:0] STEP_DX    = 4'd0;
    localparam logic [3:0] STEP_DY    = 4'd1;
    localparam logic [3:0] STEP_DZ    = 4'd2;
    localparam logic [3:0] STEP_OXX   = 4'd3;
    localparam logic [3:0] STEP_OYY   = 4'd4;
    localparam logic [3:0] STEP_OZZ   = 4'd5;
    localparam logic [3:0] STEP_RR    = 4'd6;
    localparam logic [3:0] STEP_BB    = 4'd7;
    localparam logic [3:0] STEP_DISC  = 4'd8;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TEST,
        S_CHECK,
        S_ROOT,
        S_EVAL,
        S_STEP,
        S_OUT
    } t_state;

    // Control of one target cell.
    typedef struct packed {
        logic load;
        logic live;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

>>> hw/rtl/rsn_cell.sv
// One target cell: a sphere center and its live bit, loaded by a write request,
// rotated from its neighbor during a scan, cleared after a hit. Uses rsn_pkg.
module rsn_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsn_pkg::t_cell_ctl            i_ctl,
    input  logic [rsn_pkg::CENTER_W-1:0]  i_load_center,
    input  logic [rsn_pkg::CENTER_W-1:0]  i_next_center,
    input  logic                          i_next_live,
    output logic [rsn_pkg::CENTER_W-1:0]  o_center,
    output logic                          o_live
);
    import rsn_pkg::*;

    logic [CENTER_W-1:0] r_center;
    logic                r_live;

    // The center needs no reset; it is read only once its live bit is set.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_center <= i_next_center;
        end else if (i_ctl.load) begin
            r_center <= i_load_center;
        end
    end

    // Live bit, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else if (i_ctl.shift) begin
            r_live <= i_next_live;
        end else if (i_ctl.load) begin
            r_live <= i_ctl.live;
        end else if (i_ctl.clear) begin
            r_live <= 1'b0;
        end
    end

    assign o_center = r_center;
    assign o_live   = r_live;

endmodule

>>> hw/rtl/rsn_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Uses rsn_pkg for its widths.
module rsn_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rsn_pkg::DISC_W-1:0]   i_rad,
    output logic                         o_done,
    output logic [rsn_pkg::ROOT_W-1:0]   o_root
);
    import rsn_pkg::*;

    localparam int REM_W  = ROOT_W + 2;
    localparam int WORK_W = REM_W + 2;

    logic [DISC_W-1:0] r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [WORK_W-1:0] w_work;
    logic [WORK_W-1:0] w_trial;
    logic              w_take;

    // One restoring step: bring down two bits, try to subtract 4*root+1.
    assign w_work  = {r_rem, r_rad[DISC_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_take  = (w_work >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath of the root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[DISC_W-3:0], 2'b00};
            if (w_take) begin
                r_rem  <= REM_W'(w_work - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(w_work);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> hw/rtl/ray_sphere_nearest_hit.sv
// Ray-sphere nearest hit over a ring of target cells.
// Input stream s_axis: tuser is the operation (0 write slot, 1 shoot ray),
// tdata the slot, valid mark, position and direction. Each request gives
// exactly one result on m_axis: tuser is the hit flag, tdata slot and distance.
// Configuration: a write channel (i_cfg_valid/o_cfg_ready, index, data),
// always ready; write it only while the block is idle.
// A write request updates its cell at the accepting edge; its zero result is
// loaded into the output register from S_OUT once that register is free. A
// shoot walks all NUM_TARGETS cells: the ring rotates one cell per target past
// a single test unit. A dead target passes only through S_SCAN and S_STEP; one
// missed on a negative discriminant also takes the nine steps of the shared
// multiplier and S_CHECK, and a tested one then waits on the square-root unit
// and is evaluated. After the last cell the result is loaded from S_OUT. The
// ring returns to its home position, and the nearest hit's live bit is cleared.
// One request is in work at a time. A new request is taken while a result
// waits in the output register; a stalled receiver holds the next result
// back. Reset clears all live bits and loads the register defaults.
// Configuration: a write channel of its own; a write to index 3 is ignored.
module ray_sphere_nearest_hit #(
    parameter int NUM_TARGETS = rsn_pkg::NUM_TARGETS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[2:0], target_valid[3], pos_x[19:4], pos_y[35:20], pos_z[51:36],
    // dir_x[67:52], dir_y[83:68], dir_z[99:84], zeros above
    input  logic [rsn_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // operation[0]
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hit_slot[2:0], hit_distance[17:3], zeros above
    output logic [rsn_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // hit[0]
    output logic [0:0]                      m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rsn_pkg::DIST_W-1:0]      i_cfg_data
);
    import rsn_pkg::*;

    localparam int IDX_W = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int CNT_W = $clog2(NUM_TARGETS + 1);

    // Input fields.
    logic                    w_op;
    logic [SLOT_W-1:0]       w_slot;
    logic                    w_tvalid_bit;
    logic [CENTER_W-1:0]     w_pos;
    logic signed [DIR_W-1:0] w_dx, w_dy, w_dz;

    assign w_op         = s_axis_tuser[0];
    assign w_slot       = s_axis_tdata[2:0];
    assign w_tvalid_bit = s_axis_tdata[3];
    assign w_pos        = s_axis_tdata[51:4];
    assign w_dx         = s_axis_tdata[67:52];
    assign w_dy         = s_axis_tdata[83:68];
    assign w_dz         = s_axis_tdata[99:84];

    // Registers.
    t_state                     r_state, n_state;
    logic [3:0]                 r_step;
    logic [CNT_W-1:0]           r_idx;
    logic                       r_found;
    logic [DIST_W-1:0]          r_best_t;
    logic [IDX_W-1:0]           r_best_idx;
    logic signed [POS_W-1:0]    r_ox, r_oy, r_oz;
    logic signed [DIR_W-1:0]    r_dx, r_dy, r_dz;
    logic [DIST_W-1:0]          r_radius, r_maxd, r_mind;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_accb, r_accc;
    logic signed [MUL_W-1:0]    r_b;
    logic signed [DISC_W-1:0]   r_disc;
    logic                       r_out_valid;
    logic                       r_out_hit;
    logic [SLOT_W-1:0]          r_out_slot;
    logic [DIST_W-1:0]          r_out_dist;

    // Control from the controller.
    logic c_accept, c_load, c_shift, c_clear, c_sq_start, c_out_load;

    // Ring of target cells; cell 0 is the head seen by the test unit.
    logic [CENTER_W-1:0] w_cen  [NUM_TARGETS];
    logic                w_live [NUM_TARGETS];
    t_cell_ctl           w_ctl  [NUM_TARGETS];

    for (genvar k = 0; k < NUM_TARGETS; k++) begin : g_cell
        assign w_ctl[k].load  = c_load && (32'(w_slot) == k);
        assign w_ctl[k].live  = w_tvalid_bit;
        assign w_ctl[k].shift = c_shift;
        assign w_ctl[k].clear = c_clear && (32'(r_best_idx) == k);

        rsn_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl[k]),
            .i_load_center (w_pos),
            .i_next_center (w_cen[(k + 1) % NUM_TARGETS]),
            .i_next_live   (w_live[(k + 1) % NUM_TARGETS]),
            .o_center      (w_cen[k]),
            .o_live        (w_live[k])
        );
    end

    // Origin minus head center, per axis.
    logic signed [POS_W:0] w_ocx, w_ocy, w_ocz;
    assign w_ocx = (POS_W+1)'(r_ox) - (POS_W+1)'(signed'(w_cen[0][15:0]));
    assign w_ocy = (POS_W+1)'(r_oy) - (POS_W+1)'(signed'(w_cen[0][31:16]));
    assign w_ocz = (POS_W+1)'(r_oz) - (POS_W+1)'(signed'(w_cen[0][47:32]));

    // Operand selection of the shared multiplier.
    logic signed [MUL_W-1:0] w_ma, w_mb, w_r;
    assign w_r = signed'(MUL_W'(r_radius));

    always_comb begin
        case (r_step)
            STEP_DX:  begin w_ma = MUL_W'(r_dx);  w_mb = MUL_W'(w_ocx); end
            STEP_DY:  begin w_ma = MUL_W'(r_dy);  w_mb = MUL_W'(w_ocy); end
            STEP_DZ:  begin w_ma = MUL_W'(r_dz);  w_mb = MUL_W'(w_ocz); end
            STEP_OXX: begin w_ma = MUL_W'(w_ocx); w_mb = MUL_W'(w_ocx); end
            STEP_OYY: begin w_ma = MUL_W'(w_ocy); w_mb = MUL_W'(w_ocy); end
            STEP_OZZ: begin w_ma = MUL_W'(w_ocz); w_mb = MUL_W'(w_ocz); end
            STEP_RR:  begin w_ma = w_r;           w_mb = w_r;           end
            STEP_BB:  begin w_ma = r_b;           w_mb = r_b;           end
            default:  begin w_ma = '0;            w_mb = '0;            end
        endcase
    end

    // Square-root unit.
    logic              w_sq_done;
    logic [ROOT_W-1:0] w_root;

    rsn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_sq_start),
        .i_rad   (DISC_W'(unsigned'(r_disc))),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // Near root, falling back to the far root, then the distance bounds.
    logic signed [T_W-1:0] w_nb, w_s, w_tm, w_tp, w_t, w_min, w_max;
    logic                  w_ok, w_better;

    assign w_nb  = -T_W'(r_b);
    assign w_s   = signed'(T_W'(w_root));
    assign w_tm  = w_nb - w_s;
    assign w_tp  = w_nb + w_s;
    assign w_min = signed'(T_W'(r_mind));
    assign w_max = signed'(T_W'(r_maxd));
    assign w_t   = (w_tm < w_min) ? w_tp : w_tm;
    assign w_ok  = (w_t >= w_min) && (w_t <= w_max);
    assign w_better = !r_found || (w_t < signed'(T_W'(r_best_t)));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = (w_op == OP_SHOOT) ? S_SCAN : S_OUT;
                end
            end
            S_SCAN: begin
                if (r_idx == CNT_W'(NUM_TARGETS)) begin
                    n_state = S_OUT;
                end else if (w_live[0]) begin
                    n_state = S_TEST;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_TEST: begin
                if (r_step == STEP_DISC) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = r_disc[DISC_W-1] ? S_STEP : S_ROOT;
            S_ROOT: begin
                if (w_sq_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL:  n_state = S_STEP;
            S_STEP:  n_state = S_SCAN;
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controller outputs.
    always_comb begin
        c_accept   = 1'b0;
        c_load     = 1'b0;
        c_shift    = 1'b0;
        c_clear    = 1'b0;
        c_sq_start = 1'b0;
        c_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                c_accept = s_axis_tvalid;
                c_load   = s_axis_tvalid && (w_op == OP_WRITE) &&
                           (32'(w_slot) < NUM_TARGETS);
            end
            S_SCAN:  c_clear    = (r_idx == CNT_W'(NUM_TARGETS)) && r_found;
            S_CHECK: c_sq_start = !r_disc[DISC_W-1];
            S_STEP:  c_shift    = 1'b1;
            S_OUT:   c_out_load = !r_out_valid || m_axis_tready;
            default: c_accept   = 1'b0;
        endcase
    end

    // Controller registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (c_accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_step <= '0;
            end else if (r_state == S_TEST) begin
                r_step <= r_step + 4'd1;
            end
            if (c_shift) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if ((r_state == S_EVAL) && w_ok && w_better) begin
                r_found <= 1'b1;
            end
        end
    end

    // Ray and test datapath.
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_ox <= signed'(w_pos[15:0]);
            r_oy <= signed'(w_pos[31:16]);
            r_oz <= signed'(w_pos[47:32]);
            r_dx <= w_dx;
            r_dy <= w_dy;
            r_dz <= w_dz;
        end
        r_prod <= w_ma * w_mb;
        if (r_state == S_TEST) begin
            case (r_step)
                STEP_DY:  r_accb <= ACC_W'(r_prod);
                STEP_DZ,
                STEP_OXX: r_accb <= r_accb + ACC_W'(r_prod);
                STEP_OYY: begin
                    r_b    <= MUL_W'(r_accb >>> B_SHIFT);
                    r_accc <= ACC_W'(r_prod);
                end
                STEP_OZZ,
                STEP_RR:  r_accc <= r_accc + ACC_W'(r_prod);
                STEP_BB:  r_accc <= r_accc - ACC_W'(r_prod);
                STEP_DISC: r_disc <= DISC_W'(r_prod) - DISC_W'(r_accc);
                default:  r_accc <= r_accc;
            endcase
        end
        if ((r_state == S_EVAL) && w_ok && w_better) begin
            r_best_t   <= w_t[DIST_W-1:0];
            r_best_idx <= r_idx[IDX_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= DIST_W'(148);
            r_maxd   <= DIST_W'(30720);
            r_mind   <= DIST_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HIT_RADIUS:   r_radius <= i_cfg_data;
                REG_MAX_DISTANCE: r_maxd   <= i_cfg_data;
                REG_MIN_DISTANCE: r_mind   <= i_cfg_data;
                default:          r_radius <= r_radius;
            endcase
        end
    end

    // Output register; a write request leaves r_found clear and gives zeros.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_hit   <= 1'b0;
            r_out_slot  <= '0;
            r_out_dist  <= '0;
        end else if (c_out_load) begin
            r_out_valid <= 1'b1;
            r_out_hit   <= r_found;
            r_out_slot  <= r_found ? SLOT_W'(r_best_idx) : '0;
            r_out_dist  <= r_found ? r_best_t : '0;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_dist, r_out_slot});
    assign o_cfg_ready   = 1'b1;

    // A reported hit lies within the distance bounds.
    a_hit_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |-> (r_out_dist >= r_mind && r_out_dist <= r_maxd))
        else $error("hit distance outside bounds");

    // A miss or write result carries zero slot and distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_slot == '0 && r_out_dist == '0))
        else $error("miss result not zero");

    // The scan index never runs past the table.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CNT_W'(NUM_TARGETS))
        else $error("scan index out of range");

    // A shoot request always starts a scan from the head cell.
    a_shoot_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && w_op == OP_SHOOT) |=>
        (r_state == S_SCAN && r_idx == '0 && !r_found))
        else $error("shoot did not start a scan");

endmodule
